// File: rtl/core/ffba_pkg.sv
// Shared types and codes of the first-fit block allocator.
// No dependencies; compiled before every other file of the block.
`default_nettype none

package ffba_pkg;

  // Operation codes of an input word
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Status codes of a result word
  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_NOFIT    = 2'd1,
    ST_NOTFOUND = 2'd2
  } status_t;

  // Widths fixed by the channel fields
  localparam int CFG_W    = 11;
  localparam int FIELD_W  = 10;
  localparam int FIELD_MAX = 1023;
  localparam int RESET_POOL = 1024;

endpackage

`default_nettype wire

// File: rtl/core/ffba_if.sv
// Channel interfaces of the allocator: command, result and pool size words.
// No dependencies; the status field is a plain two-bit word.
`default_nettype none

interface ffba_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [9:0] request_units;
  logic [9:0] free_offset;
  modport source (output valid, cmd, request_units, free_offset, input ready);
  modport sink   (input valid, cmd, request_units, free_offset, output ready);
endinterface

interface ffba_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [9:0] payload_offset;
  logic [9:0] largest_free;
  modport source (output valid, status, payload_offset, largest_free, input ready);
  modport sink   (input valid, status, payload_offset, largest_free, output ready);
endinterface

interface ffba_cfg_if;
  logic        valid;
  logic        ready;
  logic [10:0] pool_units;
  modport source (output valid, pool_units, input ready);
  modport sink   (input valid, pool_units, output ready);
endinterface

`default_nettype wire

// File: rtl/core/ffba_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module ffba_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and register the read word
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// File: rtl/core/first_fit_block_allocator.sv
// Channel      Dir  Payload                                      Accept
// in_ch        in   cmd, request_units, free_offset              valid & ready
// out_ch       out  status, payload_offset, largest_free         valid & ready
// cfg_ch       in   pool_units                                   valid & ready
//
// One command at a time. Each command walks the segment chain through the header
// RAM (registered read), one header per cycle, then walks the whole chain again
// for the largest free payload.
// After reset and after each pool_units write, the S_INIT state writes the first header.
// A stalled result holds in the output register; the next command may be taken.
// Depends on ffba_pkg, ffba_if and ffba_ram.
`default_nettype none

module first_fit_block_allocator
  import ffba_pkg::*;
#(
  parameter int POOL_UNITS   = 1024,
  parameter int HEADER_UNITS = 1
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ffba_in_if.sink    in_ch,
  ffba_out_if.source out_ch,
  ffba_cfg_if.sink   cfg_ch
);

  localparam int AW = $clog2(POOL_UNITS);
  localparam int PW = AW + 1;
  localparam int CW = (PW > 12) ? PW : 12;
  localparam logic [CW-1:0] HDR = CW'(HEADER_UNITS);
  localparam logic [CW-1:0] POOL_MAX = CW'(POOL_UNITS);
  localparam logic [CW-1:0] RESET_LEN =
    CW'((RESET_POOL > POOL_UNITS) ? POOL_UNITS : RESET_POOL);

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_SCAN, S_FNEXT, S_WR2, S_LSTART, S_LSCAN, S_DONE
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] pool_len_r, pool_len_nxt;
  logic          cmd_r, cmd_nxt;
  logic [9:0]    req_r, req_nxt;
  logic [9:0]    off_r, off_nxt;
  logic [CW-1:0] h_r, h_nxt;
  logic [CW-1:0] prev_h_r, prev_h_nxt;
  logic          prev_used_r, prev_used_nxt;
  logic [AW-1:0] prev_size_r, prev_size_nxt;
  logic          have_prev_r, have_prev_nxt;
  logic [AW-1:0] cur_size_r, cur_size_nxt;
  logic          nxt_in_r, nxt_in_nxt;
  logic [CW-1:0] split_addr_r, split_addr_nxt;
  logic [AW-1:0] split_size_r, split_size_nxt;
  status_t       status_r, status_nxt;
  logic [CW-1:0] grant_r, grant_nxt;
  logic [AW-1:0] best_r, best_nxt;
  logic          out_valid_r, out_valid_nxt;
  status_t       out_status_r, out_status_nxt;
  logic [9:0]    out_off_r, out_off_nxt;
  logic [9:0]    out_best_r, out_best_nxt;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [AW:0]   wr_data;
  logic [AW-1:0] rd_addr;
  logic [AW:0]   rd_data;

  logic          rd_used;
  logic [AW-1:0] rd_size;
  logic [CW-1:0] size_x;
  logic [CW-1:0] next_h;
  logic          next_ok;
  logic [CW-1:0] need;
  logic [CW-1:0] merged;
  logic [CW-1:0] best_x;
  logic [CW-1:0] cfg_x;
  logic          in_fire;

  ffba_ram #(.WIDTH(AW + 1), .DEPTH(POOL_UNITS)) u_hdr_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Decode the header word and step along the chain
  assign rd_used = rd_data[AW];
  assign rd_size = rd_data[AW-1:0];
  assign size_x  = CW'(rd_size);
  assign next_h  = h_r + HDR + size_x;
  assign next_ok = next_h < pool_len_r;
  assign need    = CW'(req_r) + HDR;
  assign merged  = CW'(cur_size_r) + ((nxt_in_r && !rd_used) ? (HDR + size_x) : '0);
  assign best_x  = CW'(best_r);
  assign cfg_x   = CW'(cfg_ch.pool_units);

  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.payload_offset = out_off_r;
  assign out_ch.largest_free   = out_best_r;

  // Sequence the walk, the header updates and the largest-free pass
  always_comb begin
    state_nxt      = state_r;
    pool_len_nxt   = pool_len_r;
    cmd_nxt        = cmd_r;
    req_nxt        = req_r;
    off_nxt        = off_r;
    h_nxt          = h_r;
    prev_h_nxt     = prev_h_r;
    prev_used_nxt  = prev_used_r;
    prev_size_nxt  = prev_size_r;
    have_prev_nxt  = have_prev_r;
    cur_size_nxt   = cur_size_r;
    nxt_in_nxt     = nxt_in_r;
    split_addr_nxt = split_addr_r;
    split_size_nxt = split_size_r;
    status_nxt     = status_r;
    grant_nxt      = grant_r;
    best_nxt       = best_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_off_nxt    = out_off_r;
    out_best_nxt   = out_best_r;
    wr_en          = 1'b0;
    wr_addr        = h_r[AW-1:0];
    wr_data        = '0;
    rd_addr        = h_r[AW-1:0];

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_INIT: begin
        wr_en     = 1'b1;
        wr_addr   = '0;
        wr_data   = {1'b0, AW'(pool_len_r - HDR)};
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_fire) begin
          cmd_nxt       = in_ch.cmd;
          req_nxt       = in_ch.request_units;
          off_nxt       = in_ch.free_offset;
          h_nxt         = '0;
          have_prev_nxt = 1'b0;
          grant_nxt     = '0;
          rd_addr       = '0;
          state_nxt     = S_SCAN;
        end
      end
      S_SCAN: begin
        if (cmd_r == CMD_ALLOC) begin
          if (!rd_used && size_x >= need) begin
            // Take this segment, split off the remainder next cycle
            wr_en          = 1'b1;
            wr_data        = {1'b1, AW'(req_r)};
            split_addr_nxt = h_r + need;
            split_size_nxt = AW'(size_x - need);
            grant_nxt      = h_r + HDR;
            status_nxt     = ST_DONE;
            state_nxt      = S_WR2;
          end else if (next_ok) begin
            h_nxt   = next_h;
            rd_addr = next_h[AW-1:0];
          end else begin
            status_nxt = ST_NOFIT;
            state_nxt  = S_LSTART;
          end
        end else begin
          if (h_r + HDR == CW'(off_r)) begin
            if (rd_used) begin
              // Fetch the neighbor after this segment
              cur_size_nxt = rd_size;
              nxt_in_nxt   = next_ok;
              rd_addr      = next_h[AW-1:0];
              status_nxt   = ST_DONE;
              state_nxt    = S_FNEXT;
            end else begin
              status_nxt = ST_NOTFOUND;
              state_nxt  = S_LSTART;
            end
          end else if (next_ok) begin
            prev_h_nxt    = h_r;
            prev_used_nxt = rd_used;
            prev_size_nxt = rd_size;
            have_prev_nxt = 1'b1;
            h_nxt         = next_h;
            rd_addr       = next_h[AW-1:0];
          end else begin
            status_nxt = ST_NOTFOUND;
            state_nxt  = S_LSTART;
          end
        end
      end
      S_FNEXT: begin
        // Free this segment, merging it with the next and the previous segment where those are free
        wr_en = 1'b1;
        if (have_prev_r && !prev_used_r) begin
          wr_addr = prev_h_r[AW-1:0];
          wr_data = {1'b0, AW'(CW'(prev_size_r) + HDR + merged)};
        end else begin
          wr_data = {1'b0, AW'(merged)};
        end
        state_nxt = S_LSTART;
      end
      S_WR2: begin
        wr_en     = 1'b1;
        wr_addr   = split_addr_r[AW-1:0];
        wr_data   = {1'b0, split_size_r};
        state_nxt = S_LSTART;
      end
      S_LSTART: begin
        rd_addr   = '0;
        h_nxt     = '0;
        best_nxt  = '0;
        state_nxt = S_LSCAN;
      end
      S_LSCAN: begin
        if (!rd_used && rd_size > best_r) begin
          best_nxt = rd_size;
        end
        if (next_ok) begin
          h_nxt   = next_h;
          rd_addr = next_h[AW-1:0];
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_off_nxt    = grant_r[9:0];
          out_best_nxt   = (best_x > CW'(FIELD_MAX)) ? 10'(FIELD_MAX) : best_x[9:0];
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase

    // Resize the pool and rebuild its first header
    if (cfg_ch.valid && cfg_ch.ready) begin
      if (cfg_x > POOL_MAX) begin
        pool_len_nxt = POOL_MAX;
      end else if (cfg_x < HDR) begin
        pool_len_nxt = HDR;
      end else begin
        pool_len_nxt = cfg_x;
      end
      state_nxt = S_INIT;
    end
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      pool_len_r  <= RESET_LEN;
      out_valid_r <= 1'b0;
      have_prev_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pool_len_r  <= pool_len_nxt;
      out_valid_r <= out_valid_nxt;
      have_prev_r <= have_prev_nxt;
    end
    cmd_r        <= cmd_nxt;
    req_r        <= req_nxt;
    off_r        <= off_nxt;
    h_r          <= h_nxt;
    prev_h_r     <= prev_h_nxt;
    prev_used_r  <= prev_used_nxt;
    prev_size_r  <= prev_size_nxt;
    cur_size_r   <= cur_size_nxt;
    nxt_in_r     <= nxt_in_nxt;
    split_addr_r <= split_addr_nxt;
    split_size_r <= split_size_nxt;
    status_r     <= status_nxt;
    grant_r      <= grant_nxt;
    best_r       <= best_nxt;
    out_status_r <= out_status_nxt;
    out_off_r    <= out_off_nxt;
    out_best_r   <= out_best_nxt;
  end

`ifndef NO_ASSERTIONS
  // A new result word appears only out of the completion state
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside completion");

  // A pool resize blocks commands while the first header is rebuilt
  a_cfg_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_ch.valid && cfg_ch.ready) |=> !in_ch.ready)
    else $error("command accepted during pool rebuild");

  // The walk cursor stays inside the pool
  a_cursor_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN || state_r == S_LSCAN) |-> (h_r < pool_len_r))
    else $error("walk cursor past pool end");

  // A granted offset comes only with a done status
  a_grant_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_off_r != 10'd0) |-> (out_status_r == ST_DONE))
    else $error("offset granted on failure");
`endif

endmodule

`default_nettype wire

// File: test/first_fit_block_allocator_test.sv
// Self-checking testbench of the first-fit block allocator: directed and random
// allocate/free words with pool resizes. Depends on ffba_pkg, ffba_if and the RTL.
`default_nettype none

module first_fit_block_allocator_test;
  import ffba_pkg::*;

  localparam int POOL = 1024;
  localparam int LIMIT = 20000000;

  typedef struct packed {
    logic       cmd;
    logic [9:0] request_units;
    logic [9:0] free_offset;
  } op_word_t;

  typedef struct packed {
    status_t    status;
    logic [9:0] payload_offset;
    logic [9:0] largest_free;
  } result_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ffba_in_if  in_ch ();
  ffba_out_if out_ch ();
  ffba_cfg_if cfg_ch ();

  first_fit_block_allocator dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor state: header flags and sizes per unit position
  bit        seg_busy [POOL];
  int        seg_len  [POOL];
  int        pool_len;
  int        live_offsets [$];

  op_word_t     op_queue [$];
  result_word_t result_queue [$];

  int  errors = 0;
  int  results_seen = 0;
  int  cycles = 0;
  bit  hold_sink = 1'b0;
  bit  send_paused = 1'b0;
  int  n_alloc_ok = 0, n_nofit = 0, n_notfound = 0, n_free_ok = 0;

  function automatic void pool_reset(int units);
    int p;
    p = units;
    if (p > POOL) p = POOL;
    if (p < 1) p = 1;
    pool_len = p;
    seg_busy[0] = 1'b0;
    seg_len[0] = p - 1;
    live_offsets.delete();
  endfunction

  function automatic int widest_hole();
    int best, h;
    best = 0;
    h = 0;
    while (h < pool_len) begin
      if (!seg_busy[h] && seg_len[h] > best) best = seg_len[h];
      h = h + 1 + seg_len[h];
    end
    return (best > 1023) ? 1023 : best;
  endfunction

  function automatic result_word_t allocate_or_free(op_word_t w);
    result_word_t r;
    int h, prev, nx, need;
    bit have_prev, hit;
    r.status = ST_NOFIT;
    r.payload_offset = '0;
    if (w.cmd == CMD_ALLOC) begin
      need = int'(w.request_units) + 1;
      h = 0;
      hit = 1'b0;
      while (h < pool_len && !hit) begin
        if (!seg_busy[h] && seg_len[h] >= need) begin
          nx = h + need;
          if (nx < pool_len) begin
            seg_busy[nx] = 1'b0;
            seg_len[nx] = seg_len[h] - need;
          end
          seg_busy[h] = 1'b1;
          seg_len[h] = w.request_units;
          r.status = ST_DONE;
          r.payload_offset = 10'(h + 1);
          live_offsets.push_back(h + 1);
          hit = 1'b1;
        end else begin
          h = h + 1 + seg_len[h];
        end
      end
    end else begin
      r.status = ST_NOTFOUND;
      h = 0;
      prev = 0;
      have_prev = 1'b0;
      hit = 1'b0;
      while (h < pool_len && !hit) begin
        if (h + 1 == int'(w.free_offset)) begin
          hit = 1'b1;
          if (seg_busy[h]) begin
            seg_busy[h] = 1'b0;
            nx = h + 1 + seg_len[h];
            if (nx < pool_len && !seg_busy[nx]) seg_len[h] += 1 + seg_len[nx];
            if (have_prev && !seg_busy[prev]) seg_len[prev] += 1 + seg_len[h];
            r.status = ST_DONE;
            foreach (live_offsets[i])
              if (live_offsets[i] == h + 1) begin
                live_offsets.delete(i);
                break;
              end
          end
        end else begin
          prev = h;
          have_prev = 1'b1;
          h = h + 1 + seg_len[h];
        end
      end
    end
    r.largest_free = 10'(widest_hole());
    return r;
  endfunction

  // Driver: offer pending words with random gaps
  int gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        result_queue.push_back(allocate_or_free(op_queue.pop_front()));
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) gap = 0;
      end
      if (gap > 0) gap--;
      in_ch.valid <= (op_queue.size() > 0 && gap == 0 && !send_paused) ||
                     (in_ch.valid && !in_ch.ready);
      if (!(in_ch.valid && !in_ch.ready) && op_queue.size() > 0) begin
        in_ch.cmd           <= op_queue[0].cmd;
        in_ch.request_units <= op_queue[0].request_units;
        in_ch.free_offset   <= op_queue[0].free_offset;
      end
    end
  end

  // Monitor: compare each result word with the oldest prediction
  result_word_t exp_r;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (result_queue.size() == 0) begin
          errors++;
          $display("%0t: unexpected result word status=%0d off=%0d largest=%0d", $time,
                   out_ch.status, out_ch.payload_offset, out_ch.largest_free);
        end else begin
          exp_r = result_queue.pop_front();
          if (out_ch.status !== exp_r.status) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $time, exp_r.status,
                     out_ch.status);
          end
          if (out_ch.payload_offset !== exp_r.payload_offset) begin
            errors++;
            $display("%0t: payload_offset expected %0d actual %0d", $time,
                     exp_r.payload_offset, out_ch.payload_offset);
          end
          if (out_ch.largest_free !== exp_r.largest_free) begin
            errors++;
            $display("%0t: largest_free expected %0d actual %0d", $time,
                     exp_r.largest_free, out_ch.largest_free);
          end
          case (exp_r.status)
            ST_DONE: begin
              if (exp_r.payload_offset != '0) n_alloc_ok++;
              else n_free_ok++;
            end
            ST_NOFIT: n_nofit++;
            default:  n_notfound++;
          endcase
        end
      end
      out_ch.ready <= !hold_sink && ($urandom_range(0, 19) == 0 ? 1'b0 : 1'b1);
    end
  end

  // Long receiver hold-off, counted in cycles
  initial begin
    repeat (3000) @(posedge clk);
    hold_sink = 1'b1;
    repeat (400) @(posedge clk);
    hold_sink = 1'b0;
  end

  // Timeout guard
  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic wait_drained();
    while (op_queue.size() > 0 || in_ch.valid || result_queue.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_pool(int units);
    wait_drained();
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.pool_units <= 11'(units);
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    pool_reset(units);
    @(posedge clk);
  endtask

  function automatic void push_alloc(int req);
    op_word_t w;
    w.cmd = CMD_ALLOC;
    w.request_units = 10'(req);
    w.free_offset = 10'($urandom_range(0, 1023));
    op_queue.push_back(w);
  endfunction

  function automatic void push_free(int off);
    op_word_t w;
    w.cmd = CMD_FREE;
    w.request_units = 10'($urandom_range(0, 1023));
    w.free_offset = 10'(off);
    op_queue.push_back(w);
  endfunction

  // Random phase: mostly small requests and mostly frees of offsets 1 to 60
  task automatic random_phase(int count, int max_req);
    int k;
    for (k = 0; k < count; k++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: push_alloc($urandom_range(0, max_req));
        4:          push_alloc($urandom_range(0, 1023));
        5, 6, 7, 8: push_free($urandom_range(1, 60));
        default:    push_free($urandom_range(0, 1023));
      endcase
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_ALLOC;
    in_ch.request_units = '0;
    in_ch.free_offset = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.pool_units = 11'(RESET_POOL);
    pool_reset(RESET_POOL);
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    repeat (3) @(posedge clk);

    // Directed: extremes, exact fit, bad frees, merges
    push_alloc(1023);
    push_alloc(0);
    push_free(0);
    push_free(1023);
    push_alloc(1021);
    push_free(1);
    push_free(1);
    wait_drained();
    write_pool(8);
    push_alloc(2);
    push_alloc(2);
    push_alloc(0);
    push_alloc(0);
    push_free(4);
    push_free(1);
    push_free(7);
    push_free(2);
    push_alloc(6);
    write_pool(2047);
    push_alloc(1022);
    push_alloc(0);
    push_free(1);
    write_pool(0);
    push_alloc(0);
    push_free(1);
    write_pool(2);
    push_alloc(0);
    push_alloc(0);

    // Random phases across several pool sizes
    write_pool(1024);
    random_phase(500, 40);
    // Pause the sender mid-phase until every pending result is back
    while (op_queue.size() > 250) @(posedge clk);
    send_paused = 1'b1;
    while (in_ch.valid || result_queue.size() > 0) @(posedge clk);
    send_paused = 1'b0;
    write_pool(64);
    random_phase(350, 12);
    write_pool(300);
    random_phase(350, 30);
    write_pool(2);
    random_phase(50, 2);
    write_pool(1024);
    random_phase(450, 60);
    write_pool($urandom_range(3, 1024));
    random_phase(125, 20);
    wait_drained();

    $display("Covered %0d results: %0d allocs, %0d frees, %0d no-fit, %0d not-found,",
             results_seen, n_alloc_ok, n_free_ok, n_nofit, n_notfound);
    $display("over pool sizes 0..2047 with sink hold-off and sender pause");
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
